[rtl/salc_pkg.sv]
package salc_pkg;

  localparam int unsigned SetBits  = 9;
  localparam int unsigned Ways     = 4;
  localparam int unsigned AddrBits = 32;
  localparam int unsigned Sets     = 1 << SetBits;
  localparam int unsigned WayW     = $clog2(Ways);
  localparam int unsigned TagW     = AddrBits - 2;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    ACT_ILOAD  = 2'd0,
    ACT_DLOAD  = 2'd1,
    ACT_STORE  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_WRITE_BACK = 3'd0,
    CFG_WRITE_ALLOC = 3'd1,
    CFG_WAYS       = 3'd2,
    CFG_OFFSET     = 3'd3,
    CFG_INDEX      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [SetBits-1:0] set;
    logic [TagW-1:0]    tag;
    action_e            action;
  } req_t;

  typedef struct packed {
    logic            hit;
    logic [WayW-1:0] way;
    logic            fill;
    logic            evict;
    logic            victim_writeback;
    logic            memory_write;
  } res_t;

  typedef struct packed {
    logic            write_back;
    logic            write_allocate;
    logic [WayW:0]   ways;
    logic [2:0]      offset_bits;
    logic [3:0]      index_bits;
  } cfg_t;

endpackage

[rtl/salc_front.sv]
module salc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [31:0]       address_i,
  input  logic [1:0]        action_i,
  input  salc_pkg::cfg_t    cfg_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output salc_pkg::req_t    q_req_o
);

  salc_pkg::req_t q_mem [salc_pkg::QDepth];
  logic wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  salc_pkg::req_t req;
  logic [2:0] ob;
  logic [3:0] ib;
  logic [31:0] sh, setm;
  logic push, pop;

  always_comb begin
    ob = (cfg_i.offset_bits < 3'd2) ? 3'd2 : cfg_i.offset_bits;
    ib = (cfg_i.index_bits > 4'(salc_pkg::SetBits)) ? 4'(salc_pkg::SetBits)
                                                   : cfg_i.index_bits;
    sh = address_i >> ob;
    setm = sh & ((32'd1 << ib) - 32'd1);
    req.set = setm[salc_pkg::SetBits-1:0];
    req.tag = salc_pkg::TagW'(sh >> ib);
    req.action = salc_pkg::action_e'(action_i);
  end

  assign ready_o   = (cnt_q != 2'(salc_pkg::QDepth));
  assign push      = valid_i && ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_req_o   = q_mem[rptr_q];
  assign wptr_d    = push ? ~wptr_q : wptr_q;
  assign rptr_d    = pop ? ~rptr_q : rptr_q;
  assign cnt_d     = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/salc_back.sv]
module salc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  salc_pkg::req_t    q_req_i,
  input  salc_pkg::cfg_t    cfg_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output salc_pkg::res_t    res_o
);

  localparam int unsigned W  = salc_pkg::Ways;
  localparam int unsigned WW = salc_pkg::WayW;
  localparam int unsigned SB = salc_pkg::SetBits;

  typedef logic [W-1:0][salc_pkg::TagW-1:0] tag_row_t;
  typedef logic [W-1:0][1:0] age_row_t;

  tag_row_t tag_mem [salc_pkg::Sets];
  logic [W-1:0] val_mem [salc_pkg::Sets];
  logic [W-1:0] dty_mem [salc_pkg::Sets];
  age_row_t age_mem [salc_pkg::Sets];

  tag_row_t     tag_rd_q;
  logic [W-1:0] val_rd_q, dty_rd_q;
  age_row_t     age_rd_q;

  salc_pkg::state_e state_q, state_d;
  logic [SB-1:0] clr_q, clr_d;
  salc_pkg::req_t req_q;
  salc_pkg::res_t res_q, res_d;
  logic res_valid_q, res_valid_d;
  logic rd_en, wr_en, clr_en;
  logic [SB-1:0] wr_set;
  tag_row_t     tag_wr;
  logic [W-1:0] val_wr, dty_wr;
  age_row_t     age_wr;

  logic [W-1:0] inuse, hitv, freev;
  logic hit, found_free, do_fill, is_store;
  logic [WW-1:0] hit_way, free_way, lru_way, tw;
  logic [1:0] lru_age, old_age;
  salc_pkg::res_t r;

  always_comb begin
    for (int i = 0; i < W; i++) begin
      inuse[i] = (i < int'(cfg_i.ways));
      hitv[i]  = inuse[i] && val_rd_q[i] && (tag_rd_q[i] == req_q.tag);
      freev[i] = inuse[i] && !val_rd_q[i];
    end
    hit = |hitv;
    found_free = |freev;
    hit_way = '0;
    free_way = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (hitv[i]) hit_way = WW'(i);
      if (freev[i]) free_way = WW'(i);
    end
    lru_way = '0;
    lru_age = age_rd_q[0];
    for (int i = 1; i < W; i++) begin
      if (inuse[i] && age_rd_q[i] > lru_age) begin
        lru_age = age_rd_q[i];
        lru_way = WW'(i);
      end
    end
    is_store = (req_q.action == salc_pkg::ACT_STORE);
    r = '0;
    do_fill = 1'b0;
    tw = '0;
    old_age = '0;
    tag_wr = tag_rd_q;
    dty_wr = dty_rd_q;
    val_wr = val_rd_q;
    age_wr = age_rd_q;
    if (req_q.action != salc_pkg::ACT_NONE) begin
      if (hit) begin
        r.hit = 1'b1;
        r.way = hit_way;
        tw = hit_way;
        old_age = age_rd_q[hit_way];
        if (is_store) begin
          if (cfg_i.write_back) dty_wr[hit_way] = 1'b1;
          else r.memory_write = 1'b1;
        end
      end else if (is_store && !cfg_i.write_allocate) begin
        r.memory_write = 1'b1;
      end else begin
        do_fill = 1'b1;
        if (found_free) begin
          tw = free_way;
          old_age = 2'(cfg_i.ways - 1'b1);
        end else begin
          tw = lru_way;
          old_age = lru_age;
          r.evict = 1'b1;
          r.victim_writeback = dty_rd_q[lru_way];
        end
        tag_wr[tw] = req_q.tag;
        val_wr[tw] = 1'b1;
        dty_wr[tw] = is_store && cfg_i.write_back;
        r.memory_write = is_store && !cfg_i.write_back;
        r.fill = 1'b1;
        r.way = tw;
      end
      if (hit || do_fill) begin
        for (int i = 0; i < W; i++) begin
          if (WW'(i) != tw && inuse[i] && val_rd_q[i] && age_rd_q[i] < old_age
              && age_rd_q[i] != 2'd3) begin
            age_wr[i] = age_rd_q[i] + 2'd1;
          end
        end
        age_wr[tw] = 2'd0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      salc_pkg::ST_CLEAR:  if (clr_q == SB'(salc_pkg::Sets - 1)) state_d = salc_pkg::ST_IDLE;
      salc_pkg::ST_IDLE:   if (q_valid_i) state_d = salc_pkg::ST_LOOKUP;
      salc_pkg::ST_LOOKUP: state_d = salc_pkg::ST_UPDATE;
      salc_pkg::ST_UPDATE: if (!res_valid_q || res_ready_i) state_d = salc_pkg::ST_IDLE;
      default:             state_d = salc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o = 1'b0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    clr_en = 1'b0;
    clr_d = clr_q;
    res_d = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    wr_set = req_q.set;
    unique case (state_q)
      salc_pkg::ST_CLEAR: begin
        clr_en = 1'b1;
        wr_set = clr_q;
        clr_d = clr_q + 1'b1;
      end
      salc_pkg::ST_IDLE: begin
        q_ready_o = 1'b1;
      end
      salc_pkg::ST_LOOKUP: begin
        rd_en = 1'b1;
      end
      salc_pkg::ST_UPDATE: begin
        if (!res_valid_q || res_ready_i) begin
          wr_en = 1'b1;
          res_d = r;
          res_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) begin
      req_q <= q_req_i;
    end
    if (rd_en) begin
      tag_rd_q <= tag_mem[req_q.set];
      val_rd_q <= val_mem[req_q.set];
      dty_rd_q <= dty_mem[req_q.set];
      age_rd_q <= age_mem[req_q.set];
    end
    if (wr_en) begin
      tag_mem[wr_set] <= tag_wr;
    end
    if (wr_en || clr_en) begin
      val_mem[wr_set] <= clr_en ? '0 : val_wr;
      dty_mem[wr_set] <= clr_en ? '0 : dty_wr;
      age_mem[wr_set] <= clr_en ? '0 : age_wr;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= salc_pkg::ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/set_assoc_lru_cache_controller.sv]
// Set-associative LRU cache tag controller.
// Request channel: valid_i/ready_o with address_i and action_i.
// Result channel: valid_o/ready_i with hit_o, way_o, fill_o, evict_o,
// victim_writeback_o and memory_write_o, one result per request, in order.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// write only while no request is outstanding.
// A front stage splits the address and queues up to two requests; the back
// stage reads the set row from the tag memory, then writes back the updated
// row and registers the result. The back stage serves one request at a time,
// stepping through idle, read and update states, and takes the next from idle.
// After reset the back stage clears valid, dirty and age of all 512 sets,
// one set per cycle; requests queue but are not served then.
// When the receiver stalls the result is held and the back stage waits,
// the queue fills and ready_o drops.
module set_assoc_lru_cache_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] address_i,
  input  logic [1:0]  action_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        hit_o,
  output logic [1:0]  way_o,
  output logic        fill_o,
  output logic        evict_o,
  output logic        victim_writeback_o,
  output logic        memory_write_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  salc_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0] ways_reg_q, ways_reg_d;
  logic q_valid, q_ready;
  salc_pkg::req_t q_req;
  salc_pkg::res_t res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    ways_reg_d = ways_reg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        salc_pkg::CFG_WRITE_BACK:  cfg_d.write_back = cfg_data_i[0];
        salc_pkg::CFG_WRITE_ALLOC: cfg_d.write_allocate = cfg_data_i[0];
        salc_pkg::CFG_WAYS:        ways_reg_d = cfg_data_i[2:0];
        salc_pkg::CFG_OFFSET:      cfg_d.offset_bits = cfg_data_i[2:0];
        salc_pkg::CFG_INDEX:       cfg_d.index_bits = cfg_data_i;
        default: ;
      endcase
    end
    if (ways_reg_d == 3'd0) cfg_d.ways = 3'd1;
    else if (ways_reg_d > 3'(salc_pkg::Ways)) cfg_d.ways = 3'(salc_pkg::Ways);
    else cfg_d.ways = ways_reg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.write_back     <= 1'b1;
      cfg_q.write_allocate <= 1'b1;
      cfg_q.ways           <= 3'd1;
      cfg_q.offset_bits    <= 3'd4;
      cfg_q.index_bits     <= 4'd9;
      ways_reg_q           <= 3'd1;
    end else begin
      cfg_q      <= cfg_d;
      ways_reg_q <= ways_reg_d;
    end
  end

  salc_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .address_i, .action_i,
    .cfg_i(cfg_q), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  salc_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .cfg_i(cfg_q), .res_valid_o(valid_o), .res_ready_i(ready_i), .res_o(res)
  );

  assign hit_o              = res.hit;
  assign way_o              = res.way;
  assign fill_o             = res.fill;
  assign evict_o            = res.evict;
  assign victim_writeback_o = res.victim_writeback;
  assign memory_write_o     = res.memory_write;

  a_cfg_ways: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.ways != 3'd0 && cfg_q.ways <= 3'(salc_pkg::Ways)) else $error("ways");
  a_hit_nofill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(hit_o && fill_o)) else $error("hit with fill");
  a_evict_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && evict_o |-> fill_o) else $error("evict without fill");
  a_wb_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && victim_writeback_o |-> evict_o) else $error("writeback without evict");

endmodule
